>>> sv/interval_slot_allocator_unit_assert.svh
// Assertion macros for the interval slot allocator.
// Used by the top level; expects clk and arst_n in scope.
`ifndef INTERVAL_SLOT_ALLOCATOR_UNIT_ASSERT_SVH
`define INTERVAL_SLOT_ALLOCATOR_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define ISA_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("isa assertion failed");

// Next-cycle implication, disabled during reset
`define ISA_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("isa assertion failed");

`endif

>>> sv/isa_pkg.sv
// Shared types and codes of the interval slot allocator.
// No dependencies.
`timescale 1ns / 1ps

package isa_pkg;

	localparam int ID_W   = 16;
	localparam int PT_W   = 16;
	localparam int SLOT_W = 3;

	// result kinds selected by the controller
	localparam logic [1:0] RES_PLACE      = 2'd0;
	localparam logic [1:0] RES_NEW_SPILL  = 2'd1;
	localparam logic [1:0] RES_VICTIM_NEW = 2'd2;
	localparam logic [1:0] RES_VICTIM_OLD = 2'd3;

	typedef struct packed {
		logic       load;
		logic       scan;
		logic       write_hit;
		logic       write_victim;
		logic       emit;
		logic [1:0] kind;
	} isa_cmd_t;

	typedef struct packed {
		logic hit;
		logic scan_done;
		logic spill_new;
		logic out_free;
	} isa_status_t;

endpackage

>>> sv/isa_if.sv
// Handshake channels of the interval slot allocator: intervals in, slot results out.
// Depends on isa_pkg.
`timescale 1ns / 1ps

interface isa_in_if;
	import isa_pkg::*;
	logic              valid;
	logic              ready;
	logic [ID_W-1:0]   value_id;
	logic [PT_W-1:0]   def_point;
	logic [PT_W-1:0]   end_point;
	logic              group_start;

	modport source (output valid, value_id, def_point, end_point, group_start,
		input ready);
	modport sink (input valid, value_id, def_point, end_point, group_start,
		output ready);
endinterface

interface isa_out_if;
	import isa_pkg::*;
	logic              valid;
	logic              ready;
	logic [ID_W-1:0]   result_id;
	logic [SLOT_W-1:0] slot_number;
	logic              spilled;
	logic              last_result;

	modport source (output valid, result_id, slot_number, spilled, last_result,
		input ready);
	modport sink (input valid, result_id, slot_number, spilled, last_result,
		output ready);
endinterface

>>> sv/interval_slot_allocator_unit.sv
// Channel    | Dir | Payload
// intervals  | in  | value_id, def_point, end_point, group_start
// slots      | out | result_id, slot_number, spilled, last_result
//
// One interval at a time. An item is latched, then the slots are read one by one from the
// slot store (one read port, registered read data) until the first fit or the last slot;
// then one result is issued, or two when it spills a resident.
// A result waits in the output register; the next item is taken meanwhile.
// Reset clears all slots; a stalled output holds the controller in its issue state.
// Top level of the interval slot allocator; depends on isa_pkg, isa_if, isa_ctrl,
// isa_dpath and the assertion macro header.
`timescale 1ns / 1ps

module interval_slot_allocator_unit #(
	parameter int SLOT_COUNT = 8
) (
	input  logic      clk,
	input  logic      arst_n,
	isa_in_if.sink    intervals,
	isa_out_if.source slots
);
	import isa_pkg::*;

	isa_cmd_t    cmd;
	isa_status_t st;

	isa_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(intervals.valid),
		.in_ready(intervals.ready),
		.st      (st),
		.cmd     (cmd)
	);

	isa_dpath #(
		.SLOT_COUNT(SLOT_COUNT)
	) u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_id      (intervals.value_id),
		.in_def     (intervals.def_point),
		.in_end     (intervals.end_point),
		.in_group   (intervals.group_start),
		.cmd        (cmd),
		.st         (st),
		.out_valid  (slots.valid),
		.out_ready  (slots.ready),
		.out_id     (slots.result_id),
		.out_slot   (slots.slot_number),
		.out_spilled(slots.spilled),
		.out_last   (slots.last_result)
	);

	// checks
`include "interval_slot_allocator_unit_assert.svh"

	`ISA_ASSERT_IMPL(a_emit_free, cmd.emit, st.out_free)
	`ISA_ASSERT_IMPL(a_write_emit, cmd.write_hit || cmd.write_victim, cmd.emit)
	`ISA_ASSERT_NEXT(a_one_at_a_time, intervals.valid && intervals.ready, !intervals.ready)
	`ISA_ASSERT_NEXT(a_pair_follows, slots.valid && slots.ready && !slots.last_result, slots.valid && slots.last_result)

endmodule

>>> sv/isa_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module isa_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 7
) (
	input  logic                                   clk,
	input  logic                                   wr_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                       wr_data,
	input  logic                                   rd_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                       rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

>>> sv/isa_ctrl.sv
// Controller of the interval slot allocator: sequences scan, update and results.
// Depends on isa_pkg.
`timescale 1ns / 1ps

module isa_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  isa_pkg::isa_status_t st,
	output isa_pkg::isa_cmd_t    cmd
);
	import isa_pkg::*;

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_SCAN   = 3'd1;
	localparam logic [2:0] S_PLACE  = 3'd2;
	localparam logic [2:0] S_DECIDE = 3'd3;
	localparam logic [2:0] S_EMIT2  = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign in_ready = (state_q == S_IDLE);

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (st.hit) begin
					state_d = S_PLACE;
				end else if (st.scan_done) begin
					state_d = S_DECIDE;
				end
			end
			S_PLACE: begin
				if (st.out_free) begin
					cmd.write_hit = 1'b1;
					cmd.emit      = 1'b1;
					cmd.kind      = RES_PLACE;
					state_d       = S_IDLE;
				end
			end
			S_DECIDE: begin
				if (st.out_free) begin
					cmd.emit = 1'b1;
					if (st.spill_new) begin
						cmd.kind = RES_NEW_SPILL;
						state_d  = S_IDLE;
					end else begin
						cmd.kind         = RES_VICTIM_NEW;
						cmd.write_victim = 1'b1;
						state_d          = S_EMIT2;
					end
				end
			end
			S_EMIT2: begin
				if (st.out_free) begin
					cmd.emit = 1'b1;
					cmd.kind = RES_VICTIM_OLD;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

>>> sv/isa_dpath.sv
// Datapath of the interval slot allocator: slot store, scan, minimum tracking, result register.
// Depends on isa_pkg and isa_ram.
`timescale 1ns / 1ps

module isa_dpath #(
	parameter int SLOT_COUNT = 8
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [isa_pkg::ID_W-1:0]    in_id,
	input  logic [isa_pkg::PT_W-1:0]    in_def,
	input  logic [isa_pkg::PT_W-1:0]    in_end,
	input  logic                        in_group,
	input  isa_pkg::isa_cmd_t           cmd,
	output isa_pkg::isa_status_t        st,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [isa_pkg::ID_W-1:0]    out_id,
	output logic [isa_pkg::SLOT_W-1:0]  out_slot,
	output logic                        out_spilled,
	output logic                        out_last
);
	import isa_pkg::*;

	localparam int USABLE = SLOT_COUNT - 1;
	localparam int IW     = (USABLE > 1) ? $clog2(USABLE) : 1;
	localparam int CW     = $clog2(USABLE + 1);
	localparam int DW     = ID_W + PT_W;
	localparam logic [SLOT_W-1:0] SPILL_SLOT = SLOT_W'(SLOT_COUNT - 1);
	localparam logic [IW-1:0]     LAST_IDX   = IW'(USABLE - 1);

	// latched interval
	logic [ID_W-1:0] id_q;
	logic [PT_W-1:0] def_q;
	logic [PT_W-1:0] end_q;

	// scan state
	logic [CW-1:0]   rd_idx_q;
	logic            rd_more;
	logic            eval_s1;
	logic [IW-1:0]   idx_s1;
	logic [USABLE-1:0] slot_valid_q;
	logic [IW-1:0]   hit_idx_q;
	logic [PT_W-1:0] min_end_q;
	logic [IW-1:0]   min_idx_q;
	logic [ID_W-1:0] min_owner_q;

	// store access
	logic            wr_en;
	logic [IW-1:0]   wr_addr;
	logic [DW-1:0]   rd_data;
	logic [ID_W-1:0] rd_owner;
	logic [PT_W-1:0] rd_end;
	logic            fit;
	logic            rd_en;

	// output register
	logic              out_valid_q;
	logic [ID_W-1:0]   out_id_q;
	logic [SLOT_W-1:0] out_slot_q;
	logic              out_spilled_q;
	logic              out_last_q;
	logic [IW+SLOT_W-1:0] hit_wide;
	logic [IW+SLOT_W-1:0] min_wide;

	assign rd_more  = (rd_idx_q < CW'(USABLE));
	assign rd_en    = cmd.scan & rd_more;
	assign rd_owner = rd_data[DW-1:PT_W];
	assign rd_end   = rd_data[PT_W-1:0];
	assign fit      = !slot_valid_q[idx_s1] || (def_q > rd_end);

	assign wr_en   = cmd.write_hit | cmd.write_victim;
	assign wr_addr = cmd.write_hit ? hit_idx_q : min_idx_q;

	isa_ram #(
		.WIDTH(DW),
		.DEPTH(USABLE)
	) u_slots (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data({id_q, end_q}),
		.rd_en  (rd_en),
		.rd_addr(rd_idx_q[IW-1:0]),
		.rd_data(rd_data)
	);

	// status back to the controller
	assign st.hit       = eval_s1 & fit;
	assign st.scan_done = eval_s1 & !fit & (idx_s1 == LAST_IDX);
	assign st.spill_new = (min_end_q > end_q);
	assign st.out_free  = !out_valid_q | out_ready;

	// interval latch
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			id_q  <= in_id;
			def_q <= in_def;
			end_q <= in_end;
		end
	end

	// read sequencing and evaluation stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_idx_q <= '0;
			eval_s1  <= 1'b0;
		end else begin
			eval_s1 <= rd_en;
			if (cmd.load) begin
				rd_idx_q <= '0;
			end else if (rd_en) begin
				rd_idx_q <= rd_idx_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			idx_s1 <= rd_idx_q[IW-1:0];
		end
	end

	// first fit and running minimum, lowest slot wins ties
	always_ff @(posedge clk) begin
		if (cmd.scan && eval_s1) begin
			if (fit) begin
				hit_idx_q <= idx_s1;
			end
			if ((idx_s1 == '0) || (min_end_q > rd_end)) begin
				min_end_q   <= rd_end;
				min_idx_q   <= idx_s1;
				min_owner_q <= rd_owner;
			end
		end
	end

	// valid bits: cleared on group start, set on allocation
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_valid_q <= '0;
		end else if (cmd.load && in_group) begin
			slot_valid_q <= '0;
		end else if (wr_en) begin
			slot_valid_q[wr_addr] <= 1'b1;
		end
	end

	// result register
	assign hit_wide = {{SLOT_W{1'b0}}, hit_idx_q};
	assign min_wide = {{SLOT_W{1'b0}}, min_idx_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			case (cmd.kind)
				RES_PLACE: begin
					out_id_q      <= id_q;
					out_slot_q    <= hit_wide[SLOT_W-1:0];
					out_spilled_q <= 1'b0;
					out_last_q    <= 1'b1;
				end
				RES_NEW_SPILL: begin
					out_id_q      <= id_q;
					out_slot_q    <= SPILL_SLOT;
					out_spilled_q <= 1'b1;
					out_last_q    <= 1'b1;
				end
				RES_VICTIM_NEW: begin
					out_id_q      <= id_q;
					out_slot_q    <= min_wide[SLOT_W-1:0];
					out_spilled_q <= 1'b0;
					out_last_q    <= 1'b0;
				end
				RES_VICTIM_OLD: begin
					out_id_q      <= min_owner_q;
					out_slot_q    <= SPILL_SLOT;
					out_spilled_q <= 1'b1;
					out_last_q    <= 1'b1;
				end
				default: begin
					out_id_q      <= id_q;
					out_slot_q    <= SPILL_SLOT;
					out_spilled_q <= 1'b1;
					out_last_q    <= 1'b1;
				end
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign out_id      = out_id_q;
	assign out_slot    = out_slot_q;
	assign out_spilled = out_spilled_q;
	assign out_last    = out_last_q;

endmodule

>>> tb/isa_slot_checker.sv
// Slot result checker for the interval slot allocator: predicts and compares.
// Depends on isa_pkg and the isa_in_if / isa_out_if channel interfaces.
`timescale 1ns / 1ps

module isa_slot_checker #(
	parameter int SLOT_COUNT = 8
) (
	input  logic clk,
	input  logic arst_n,
	isa_in_if    intervals,
	isa_out_if   slots,
	output int   failures,
	output int   pending
);
	import isa_pkg::*;

	localparam int USABLE = SLOT_COUNT - 1;
	localparam logic [SLOT_W-1:0] SPILL_SLOT = SLOT_W'(SLOT_COUNT - 1);

	typedef struct packed {
		logic [ID_W-1:0]   id;
		logic [SLOT_W-1:0] slot;
		logic              spilled;
		logic              last_res;
	} slot_res_t;

	// shadow of the slot store
	logic            slot_busy [USABLE];
	logic [ID_W-1:0] slot_id   [USABLE];
	logic [PT_W-1:0] slot_last [USABLE];

	slot_res_t slot_results_q[$];
	int        fail_tally;

	// append one predicted result at the tail
	function automatic void enqueue_result(input slot_res_t r);
		slot_results_q.insert(slot_results_q.size(), r);
	endfunction

	// first fit, else spill whichever of residents and newcomer dies first
	function automatic void allocate(input logic [ID_W-1:0] id, input logic [PT_W-1:0] def_pt,
		input logic [PT_W-1:0] end_pt, input logic grp);
		int              pick;
		logic [PT_W-1:0] lowest;
		logic [ID_W-1:0] evicted;
		if (grp) begin
			for (int i = 0; i < USABLE; i++)
				slot_busy[i] = 1'b0;
		end
		for (int i = 0; i < USABLE; i++) begin
			if (!slot_busy[i] || def_pt > slot_last[i]) begin
				slot_busy[i] = 1'b1;
				slot_id[i]   = id;
				slot_last[i] = end_pt;
				enqueue_result(slot_res_t'{id, SLOT_W'(i), 1'b0, 1'b1});
				return;
			end
		end
		pick   = 0;
		lowest = slot_last[0];
		for (int i = 1; i < USABLE; i++) begin
			if (lowest > slot_last[i]) begin
				lowest = slot_last[i];
				pick   = i;
			end
		end
		// newcomer loses only when strictly earlier than every resident
		if (lowest > end_pt) begin
			enqueue_result(slot_res_t'{id, SPILL_SLOT, 1'b1, 1'b1});
			return;
		end
		evicted         = slot_id[pick];
		slot_id[pick]   = id;
		slot_last[pick] = end_pt;
		enqueue_result(slot_res_t'{id, SLOT_W'(pick), 1'b0, 1'b0});
		enqueue_result(slot_res_t'{evicted, SPILL_SLOT, 1'b1, 1'b1});
	endfunction

	initial fail_tally = 0;

	// inputs first, so a same-edge result never races its own prediction
	always @(posedge clk or negedge arst_n) begin
		slot_res_t oldest;
		if (!arst_n) begin
			for (int i = 0; i < USABLE; i++)
				slot_busy[i] = 1'b0;
			slot_results_q.delete();
		end else begin
			if (intervals.valid && intervals.ready)
				allocate(intervals.value_id, intervals.def_point, intervals.end_point,
					intervals.group_start);
			if (slots.valid && slots.ready) begin
				if (slot_results_q.size() == 0) begin
					$error("unexpected slot item: result_id %0d slot %0d", slots.result_id,
						slots.slot_number);
					fail_tally++;
				end else begin
					oldest = slot_results_q.pop_front();
					if (slots.result_id !== oldest.id) begin
						$error("result_id: expected %0d, got %0d", oldest.id, slots.result_id);
						fail_tally++;
					end
					if (slots.slot_number !== oldest.slot) begin
						$error("slot_number: expected %0d, got %0d", oldest.slot,
							slots.slot_number);
						fail_tally++;
					end
					if (slots.spilled !== oldest.spilled) begin
						$error("spilled: expected %0b, got %0b", oldest.spilled, slots.spilled);
						fail_tally++;
					end
					if (slots.last_result !== oldest.last_res) begin
						$error("last_result: expected %0b, got %0b", oldest.last_res,
							slots.last_result);
						fail_tally++;
					end
				end
			end
		end
		pending  <= slot_results_q.size();
		failures <= fail_tally;
	end

endmodule

>>> tb/interval_slot_allocator_unit_tb.sv
// Testbench top for the interval slot allocator: clock, reset, interval and stall traffic.
// Depends on isa_pkg, isa_if, the allocator RTL and isa_slot_checker.
`timescale 1ns / 1ps

module interval_slot_allocator_unit_tb;
	import isa_pkg::*;

	localparam int SLOT_COUNT   = 8;
	localparam int RANDOM_ITEMS = 1050;
	localparam int HOLD_CYCLES  = 400;
	localparam int IDLE_LIMIT   = HOLD_CYCLES + 2000;
	localparam int TAIL_CYCLES  = 2 * (SLOT_COUNT + 2) + 10;

	logic clk;
	logic arst_n;
	int   failures;
	int   pending;
	int   sent;
	int   idle_cycles;
	bit   tx_calm;
	bit   hold_req;

	isa_in_if  intervals();
	isa_out_if slots();

	interval_slot_allocator_unit #(.SLOT_COUNT(SLOT_COUNT)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.intervals (intervals),
		.slots     (slots)
	);

	isa_slot_checker #(.SLOT_COUNT(SLOT_COUNT)) checker_i (
		.clk       (clk),
		.arst_n    (arst_n),
		.intervals (intervals),
		.slots     (slots),
		.failures  (failures),
		.pending   (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// mostly short gaps, now and then a long one
	function automatic int sender_gap();
		int r;
		r = $urandom_range(0, 99);
		if (tx_calm || r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// entered and left just after a falling edge
	task automatic send_interval(input logic [ID_W-1:0] id, input logic [PT_W-1:0] def_pt,
		input logic [PT_W-1:0] end_pt, input logic grp);
		int gap;
		gap = sender_gap();
		if (gap > 0) begin
			intervals.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		intervals.valid       = 1'b1;
		intervals.value_id    = id;
		intervals.def_point   = def_pt;
		intervals.end_point   = end_pt;
		intervals.group_start = grp;
		@(posedge clk);
		while (!intervals.ready)
			@(posedge clk);
		sent++;
		@(negedge clk);
	endtask

	// one function's worth of intervals, or pure noise
	task automatic run_function(input bit noisy);
		int              len;
		int              span;
		int              next_pt;
		logic [PT_W-1:0] pos;
		logic [PT_W-1:0] end_v;
		logic            grp;
		len  = $urandom_range(4, 40);
		span = ($urandom_range(0, 3) == 0) ? $urandom_range(200, 3000) : $urandom_range(8, 120);
		pos  = PT_W'($urandom_range(0, 65535));
		for (int k = 0; k < len; k++) begin
			if (noisy) begin
				send_interval(ID_W'($urandom), PT_W'($urandom), PT_W'($urandom),
					1'($urandom_range(0, 1)));
			end else begin
				next_pt = pos + $urandom_range(0, 4);
				pos     = (next_pt > 65535) ? 16'hFFFF : PT_W'(next_pt);
				next_pt = pos + $urandom_range(0, span);
				end_v   = (next_pt > 65535) ? 16'hFFFF : PT_W'(next_pt);
				// a last use ahead of its definition now and then
				if ($urandom_range(0, 39) == 0)
					end_v = PT_W'($urandom_range(0, pos));
				grp = (k == 0) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 99) == 0);
				send_interval(ID_W'($urandom), pos, end_v, grp);
			end
		end
	endtask

	// receiver: random stalls, calm stretches, and long hold-offs on request
	initial begin
		int r;
		int n;
		slots.ready = 1'b0;
		wait (arst_n);
		@(negedge clk);
		forever begin
			r = $urandom_range(0, 99);
			if (hold_req) begin
				hold_req    = 1'b0;
				slots.ready = 1'b0;
				n           = HOLD_CYCLES;
			end else if (r < 10) begin
				slots.ready = 1'b1;
				n           = $urandom_range(50, 150);
			end else if (r < 60) begin
				slots.ready = 1'b1;
				n           = $urandom_range(1, 20);
			end else if (r < 95) begin
				slots.ready = 1'b0;
				n           = $urandom_range(1, 3);
			end else begin
				slots.ready = 1'b0;
				n           = $urandom_range(10, 40);
			end
			repeat (n) @(negedge clk);
		end
	end

	// watchdog on cycles with no item moving on either channel
	always @(posedge clk) begin
		if (!arst_n || (intervals.valid && intervals.ready) || (slots.valid && slots.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		int directed;
		arst_n                = 1'b0;
		sent                  = 0;
		idle_cycles           = 0;
		tx_calm               = 1'b0;
		hold_req              = 1'b0;
		intervals.valid       = 1'b0;
		intervals.value_id    = '0;
		intervals.def_point   = '0;
		intervals.end_point   = '0;
		intervals.group_start = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// fill every slot, extremes of id and points
		send_interval(16'h0000, 16'h0000, 16'hFFFF, 1'b1);
		send_interval(16'hFFFF, 16'h0000, 16'hFFFF, 1'b0);
		for (int k = 0; k < 5; k++)
			send_interval(ID_W'(2 + k), 16'd10, PT_W'(1000 + k), 1'b0);
		// full: newcomer ends first and is spilled, end before definition too
		send_interval(16'd100, 16'd20, 16'd5, 1'b0);
		// newcomer ends after the earliest resident: resident goes
		send_interval(16'd101, 16'd30, 16'd1002, 1'b0);
		// reuse of a slot whose resident has died
		send_interval(16'd102, 16'd1003, 16'd1003, 1'b0);
		send_interval(16'd103, 16'hFFFF, 16'h0000, 1'b0);
		send_interval(16'h5555, 16'h0000, 16'h0000, 1'b0);
		// group start empties the slots
		send_interval(16'hAAAA, 16'h8000, 16'h7FFF, 1'b1);
		// equal ends everywhere: victim is the lowest slot
		for (int k = 0; k < 7; k++)
			send_interval(ID_W'(200 + k), 16'd0, 16'd500, k == 0);
		send_interval(16'd207, 16'd1, 16'd600, 1'b0);
		send_interval(16'd208, 16'd2, 16'd400, 1'b0);
		send_interval(16'd209, 16'd501, 16'hFFFF, 1'b0);
		directed = sent;

		// random functions; back-pressure hold-off at the start and half way
		hold_req = 1'b1;
		tx_calm  = 1'b1;
		run_function(1'b0);
		while (sent < directed + RANDOM_ITEMS) begin
			if (sent >= directed + RANDOM_ITEMS / 2 && sent < directed + RANDOM_ITEMS / 2 + 40) begin
				hold_req = 1'b1;
				tx_calm  = 1'b1;
			end else begin
				tx_calm = ($urandom_range(0, 3) == 0);
			end
			run_function($urandom_range(0, 6) == 0);
		end
		intervals.valid = 1'b0;

		while (pending != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (failures == 0 && pending == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
